// ===== rtl/core/pll_divider_select_defines.svh =====
// ----------------------------------------------------------------------------
// pll_divider_select_defines
// assertion macros shared by the pll divider select modules
// ----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SELECT_DEFINES_SVH
`define PLL_DIVIDER_SELECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLLDS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pll divider select: check failed");

// next-cycle implication, checked outside reset
`define PLLDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pll divider select: check failed");

`endif

// ===== rtl/core/pllds_pkg.sv =====
// ----------------------------------------------------------------------------
// pllds_pkg
// types and constants for the pll post and feedback divider select block
// ----------------------------------------------------------------------------
package pllds_pkg;

  localparam int CLK_W    = 16;
  localparam int VCO_W    = 20;
  localparam int FB_W     = 30;
  localparam int RATIO_W  = 5;
  localparam int CODE_W   = 3;
  localparam int RDIV_W   = 10;
  localparam int THIRD_W  = 13;
  localparam int NUM_POST = 8;

  // one quotient bit per divider stage
  localparam int DIV_STAGES = FB_W;

  // depth of the queue in front of the result ports
  localparam int OUT_DEPTH = 2;

  // x / 3 as (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x below 2**14
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  // post divider ratios in search order, index 0 first
  localparam logic [NUM_POST-1:0][RATIO_W-1:0] POST_RATIO =
    {5'd12, 5'd6, 5'd16, 5'd3, 5'd8, 5'd4, 5'd2, 5'd1};
  localparam logic [NUM_POST-1:0][CODE_W-1:0] POST_CODE =
    {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  localparam logic [CLK_W-1:0]  RST_MAX_VCO = 16'd35000;
  localparam logic [CLK_W-1:0]  RST_MIN_VCO = 16'd20000;
  localparam logic [CLK_W-1:0]  RST_REF_CLK = 16'd2700;
  localparam logic [RDIV_W-1:0] RST_REF_DIV = 10'd12;

  typedef enum logic [1:0] {
    CFG_MAX_VCO = 2'd0,
    CFG_MIN_VCO = 2'd1,
    CFG_REF_CLK = 2'd2,
    CFG_REF_DIV = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CLK_W-1:0]  max_vco;
    logic [CLK_W-1:0]  min_vco;
    logic [CLK_W-1:0]  ref_clk;
    logic [RDIV_W-1:0] ref_div;
  } cfg_t;

  // classified request, front to back
  typedef struct packed {
    logic [CLK_W-1:0]   clamped_clock;
    logic [VCO_W-1:0]   vco_freq;
    logic [RATIO_W-1:0] post_divider;
    logic [CODE_W-1:0]  post_code;
    logic               no_fit;
  } class_t;

  typedef struct packed {
    class_t          item;
    logic [FB_W-1:0] feedback_divider;
  } result_t;

endpackage

// ===== rtl/core/pllds_queue.sv =====
// ----------------------------------------------------------------------------
// pllds_queue
// small register queue with push/full and pop/empty handshakes
// ----------------------------------------------------------------------------
`include "pll_divider_select_defines.svh"

module pllds_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] data_in,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] data_out,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // a lone pop always frees a slot
  `PLLDS_ASSERT_NEXT(a_pop_frees, clk, rst, do_pop && !do_push, !full)

endmodule

// ===== rtl/core/pllds_front.sv =====
// ----------------------------------------------------------------------------
// pllds_front
// clamps the request and picks the first post divider that lands in range
// ----------------------------------------------------------------------------
`include "pll_divider_select_defines.svh"

module pllds_front
  import pllds_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  input  logic [CLK_W-1:0] pixel_clock,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output class_t           out_item
);

  logic               f1_valid;
  logic [CLK_W-1:0]   f1_clk;
  logic               f1_low;
  logic [THIRD_W-1:0] f1_third;
  logic               f2_valid;
  class_t             f2_item;

  logic                           adv;
  logic [CLK_W-1:0]               c0;
  logic [VCO_W-1:0]               c0_x12;
  logic [FB_W-1:0]                third_prod;
  logic [CLK_W-1:0]               clk_sel;
  logic [NUM_POST-1:0][VCO_W-1:0] vco_try;
  logic [NUM_POST-1:0]            fit;
  class_t                         pick;

  assign adv       = !f2_valid || out_ready;
  assign full      = !adv;
  assign out_valid = f2_valid;
  assign out_item  = f2_item;

  // stage 1: clamp to max, flag a request too low, min / 12
  always_comb begin
    c0         = (pixel_clock > cfg.max_vco) ? cfg.max_vco : pixel_clock;
    c0_x12     = (VCO_W'(c0) << 3) + (VCO_W'(c0) << 2);
    third_prod = FB_W'(cfg.min_vco[CLK_W-1:2]) * FB_W'(DIV3_RECIP);
  end

  // stage 2: try every ratio at once, first fit in list order wins
  always_comb begin
    clk_sel = f1_low ? CLK_W'(f1_third) : f1_clk;
    for (int i = 0; i < NUM_POST; i++) begin
      vco_try[i] = VCO_W'(clk_sel) * VCO_W'(POST_RATIO[i]);
      fit[i]     = (vco_try[i] >= VCO_W'(cfg.min_vco)) &&
                   (vco_try[i] <= VCO_W'(cfg.max_vco));
    end
    pick.clamped_clock = clk_sel;
    pick.vco_freq      = vco_try[NUM_POST-1];
    pick.post_divider  = '0;
    pick.post_code     = '0;
    pick.no_fit        = 1'b1;
    for (int i = NUM_POST - 1; i >= 0; i--) begin
      if (fit[i]) begin
        pick.vco_freq     = vco_try[i];
        pick.post_divider = POST_RATIO[i];
        pick.post_code    = POST_CODE[i];
        pick.no_fit       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_clk   <= c0;
      f1_low   <= (c0_x12 < VCO_W'(cfg.min_vco));
      f1_third <= third_prod[DIV3_SHIFT +: THIRD_W];
      f2_item  <= pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= push;
      f2_valid <= f1_valid;
    end
  end

  `PLLDS_ASSERT_IMPL(a_fit_in_range, clk, rst, f2_valid && !f2_item.no_fit, (f2_item.vco_freq >= VCO_W'(cfg.min_vco)) && (f2_item.vco_freq <= VCO_W'(cfg.max_vco)))

endmodule

// ===== rtl/core/pllds_back.sv =====
// ----------------------------------------------------------------------------
// pllds_back
// feedback divider: scale by the reference divider, then a pipelined
// restoring divide by the reference clock, one quotient bit per stage
// ----------------------------------------------------------------------------
`include "pll_divider_select_defines.svh"

module pllds_back
  import pllds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  class_t  in_item,
  output logic    in_ready,
  input  logic    out_full,
  output logic    out_push,
  output result_t out_item
);

  logic                  dvalid [DIV_STAGES+1];
  class_t                dinfo  [DIV_STAGES+1];
  logic [FB_W-1:0]       dnum   [DIV_STAGES+1];
  logic [CLK_W-1:0]      drem   [DIV_STAGES+1];

  logic                  adv;
  logic [FB_W-1:0]       num_in;
  logic [FB_W-1:0]       num_next [DIV_STAGES+1];
  logic [CLK_W-1:0]      rem_next [DIV_STAGES+1];
  logic [CLK_W:0]        trial    [DIV_STAGES+1];
  logic                  ge       [DIV_STAGES+1];

  assign adv      = !dvalid[DIV_STAGES] || !out_full;
  assign in_ready = adv;
  assign out_push = dvalid[DIV_STAGES] && !out_full;

  assign out_item.item             = dinfo[DIV_STAGES];
  assign out_item.feedback_divider = dnum[DIV_STAGES];

  // numerator stays below 2**30 for every legal vco
  assign num_in = FB_W'(cfg.ref_div) * FB_W'(in_item.vco_freq) +
                  FB_W'(cfg.ref_clk[CLK_W-1:1]);

  // a zero divisor sets every quotient bit, which is the saturated value
  always_comb begin
    num_next[0] = '0;
    rem_next[0] = '0;
    trial[0]    = '0;
    ge[0]       = 1'b0;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      trial[k]    = {drem[k-1], dnum[k-1][FB_W-1]};
      ge[k]       = (trial[k] >= {1'b0, cfg.ref_clk});
      rem_next[k] = ge[k] ? CLK_W'(trial[k] - {1'b0, cfg.ref_clk})
                          : trial[k][CLK_W-1:0];
      num_next[k] = {dnum[k-1][FB_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dinfo[0] <= in_item;
      dnum[0]  <= num_in;
      drem[0]  <= '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dinfo[k] <= dinfo[k-1];
        dnum[k]  <= num_next[k];
        drem[k]  <= rem_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dvalid[k] <= 1'b0;
      end
    end else if (adv) begin
      dvalid[0] <= in_valid;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        dvalid[k] <= dvalid[k-1];
      end
    end
  end

  // remainder of a finished divide is below the divisor
  `PLLDS_ASSERT_IMPL(a_rem_below_div, clk, rst, dvalid[DIV_STAGES] && (cfg.ref_clk != '0), drem[DIV_STAGES] < cfg.ref_clk)

endmodule

// ===== rtl/core/pll_divider_select.sv =====
// ----------------------------------------------------------------------------
// pll_divider_select
// picks the pll post divider and rounded feedback divider for a dot clock
// ----------------------------------------------------------------------------
// usage:
//   requests enter on push/full with pixel_clock; a request transfers on a
//   clock edge with push high and full low. results leave on empty/pop; the
//   oldest result sits on the result ports while empty is low and transfers
//   on an edge with pop high.
//   the user must write the four limit registers via cfg_wr/cfg_index/cfg_data
//   only while no request is in flight; the block itself does not enforce it.
// pipeline and throughput:
//   a request passes through the front stages (clamp, then divider search),
//   the middle queue, the scaling multiply register, 30 stages of the
//   feedback divide, one per quotient bit, and the output queue. one request
//   per cycle is taken for as long as results are popped.
// reset:
//   rst clears all queues and pipeline valids and loads the default limits.
// stall:
//   when pop stays low the output queue fills, the divider pipe holds, the
//   middle queue takes up to QUEUE_DEPTH more items, then full rises.
// ----------------------------------------------------------------------------
`include "pll_divider_select_defines.svh"

module pll_divider_select
  import pllds_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_index,
  input  logic [CLK_W-1:0]   cfg_data,
  input  logic               push,
  input  logic [CLK_W-1:0]   pixel_clock,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic [CLK_W-1:0]   clamped_clock,
  output logic [VCO_W-1:0]   vco_freq,
  output logic [FB_W-1:0]    feedback_divider,
  output logic [RATIO_W-1:0] post_divider,
  output logic [CODE_W-1:0]  post_code,
  output logic [FB_W-1:0]    divider_word,
  output logic               no_fit
);

  cfg_t    cfg;
  logic    front_valid;
  logic    front_ready;
  class_t  front_item;
  logic    mid_full;
  logic    mid_empty;
  logic    back_ready;
  logic [$bits(class_t)-1:0]  mid_dout;
  logic    out_full;
  logic    out_push;
  result_t back_item;
  logic [$bits(result_t)-1:0] out_dout;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_vco <= RST_MAX_VCO;
      cfg.min_vco <= RST_MIN_VCO;
      cfg.ref_clk <= RST_REF_CLK;
      cfg.ref_div <= RST_REF_DIV;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_VCO: cfg.max_vco <= cfg_data;
        CFG_MIN_VCO: cfg.min_vco <= cfg_data;
        CFG_REF_CLK: cfg.ref_clk <= cfg_data;
        CFG_REF_DIV: cfg.ref_div <= cfg_data[RDIV_W-1:0];
      endcase
    end
  end

  pllds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .pixel_clock (pixel_clock),
    .full        (full),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_item    (front_item)
  );

  assign front_ready = !mid_full;

  pllds_queue #(
    .WIDTH ($bits(class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .data_in  (front_item),
    .full     (mid_full),
    .pop      (back_ready),
    .data_out (mid_dout),
    .empty    (mid_empty)
  );

  pllds_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!mid_empty),
    .in_item  (class_t'(mid_dout)),
    .in_ready (back_ready),
    .out_full (out_full),
    .out_push (out_push),
    .out_item (back_item)
  );

  pllds_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .data_in  (back_item),
    .full     (out_full),
    .pop      (pop),
    .data_out (out_dout),
    .empty    (empty)
  );

  assign res              = result_t'(out_dout);
  assign clamped_clock    = res.item.clamped_clock;
  assign vco_freq         = res.item.vco_freq;
  assign feedback_divider = res.feedback_divider;
  assign post_divider     = res.item.post_divider;
  assign post_code        = res.item.post_code;
  assign no_fit           = res.item.no_fit;
  assign divider_word     = res.feedback_divider | (FB_W'(res.item.post_code) << 16);

  // a failed search carries no post divider and no code to the ports
  `PLLDS_ASSERT_IMPL(a_no_fit_zero, clk, rst, !empty && no_fit, {post_divider, post_code} == '0)

endmodule

// ===== dv/tb_pll_divider_select.sv =====
// ----------------------------------------------------------------------------
// tb_pll_divider_select
// self-checking regression for the pll post and feedback divider select block
// ----------------------------------------------------------------------------
// requests go in through the push/full queue port and results come back through
// empty/pop. A scoreboard predicts every result from its own copy of the limit
// registers and checks the results in order, field by field. Directed requests
// cover each post divider, the clamps and the corner settings. Random phases
// then load new limits and use three idle patterns on the sender and receiver.
// ----------------------------------------------------------------------------
module tb_pll_divider_select
  import pllds_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [63:0] FB_ALL_ONES = 64'h3FFF_FFFF;

  typedef struct {
    logic [CLK_W-1:0]   clamped_clock;
    logic [VCO_W-1:0]   vco_freq;
    logic [FB_W-1:0]    feedback_divider;
    logic [RATIO_W-1:0] post_divider;
    logic [CODE_W-1:0]  post_code;
    logic [FB_W-1:0]    divider_word;
    logic               no_fit;
  } divider_pick_t;

  class divider_scoreboard;
    cfg_t          limits;
    divider_pick_t pending[$];
    int            errors;

    function new();
      limits = '{RST_MAX_VCO, RST_MIN_VCO, RST_REF_CLK, RST_REF_DIV};
      errors = 0;
    endfunction

    function void set_limit(cfg_idx_t idx, logic [CLK_W-1:0] value);
      case (idx)
        CFG_MAX_VCO: limits.max_vco = value;
        CFG_MIN_VCO: limits.min_vco = value;
        CFG_REF_CLK: limits.ref_clk = value;
        CFG_REF_DIV: limits.ref_div = value[RDIV_W-1:0];
        default: ;
      endcase
    endfunction

    // search order of the post dividers; the code is the position in this list
    function void note_request(logic [CLK_W-1:0] pixel);
      int unsigned   ratios[NUM_POST] = '{1, 2, 4, 8, 3, 16, 6, 12};
      divider_pick_t pick;
      logic [31:0]   dot;
      logic [31:0]   vco;
      logic [63:0]   fb;
      logic [2:0]    code;
      logic [4:0]    ratio;
      logic          fit;
      dot = {16'd0, pixel};
      if (dot > {16'd0, limits.max_vco}) dot = {16'd0, limits.max_vco};
      if (dot * 32'd12 < {16'd0, limits.min_vco}) dot = {16'd0, limits.min_vco} / 32'd12;
      vco = 0;
      code = 0;
      ratio = 0;
      fit = 1'b0;
      for (int i = 0; i < NUM_POST; i++) begin
        if (!fit) begin
          vco = ratios[i] * dot;
          if (vco >= {16'd0, limits.min_vco} && vco <= {16'd0, limits.max_vco}) begin
            fit = 1'b1;
            ratio = 5'(ratios[i]);
            code = 3'(i);
          end
        end
      end
      if (limits.ref_clk == '0) begin
        fb = FB_ALL_ONES;
      end else begin
        fb = (64'(limits.ref_div) * 64'(vco) + 64'(limits.ref_clk / 2)) / 64'(limits.ref_clk);
        if (fb > FB_ALL_ONES) fb = FB_ALL_ONES;
      end
      pick.clamped_clock    = dot[CLK_W-1:0];
      pick.vco_freq         = vco[VCO_W-1:0];
      pick.feedback_divider = fb[FB_W-1:0];
      pick.post_divider     = ratio;
      pick.post_code        = code;
      pick.divider_word     = fb[FB_W-1:0] | (FB_W'(code) << 16);
      pick.no_fit           = !fit;
      pending.push_back(pick);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors < 200) begin
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      end
    endtask

    task check_result(divider_pick_t got);
      divider_pick_t want;
      if (pending.size() == 0) begin
        report("unexpected result, clamped_clock", got.clamped_clock, 0);
      end else begin
        want = pending.pop_front();
        if (got.clamped_clock !== want.clamped_clock)
          report("clamped_clock", got.clamped_clock, want.clamped_clock);
        if (got.vco_freq !== want.vco_freq)
          report("vco_freq", got.vco_freq, want.vco_freq);
        if (got.feedback_divider !== want.feedback_divider)
          report("feedback_divider", got.feedback_divider, want.feedback_divider);
        if (got.post_divider !== want.post_divider)
          report("post_divider", got.post_divider, want.post_divider);
        if (got.post_code !== want.post_code)
          report("post_code", got.post_code, want.post_code);
        if (got.divider_word !== want.divider_word)
          report("divider_word", got.divider_word, want.divider_word);
        if (got.no_fit !== want.no_fit)
          report("no_fit", got.no_fit, want.no_fit);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr = 1'b0;
  logic [1:0]         cfg_index = CFG_MAX_VCO;
  logic [CLK_W-1:0]   cfg_data = '0;
  logic               push = 1'b0;
  logic [CLK_W-1:0]   pixel_clock = '0;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic [CLK_W-1:0]   clamped_clock;
  logic [VCO_W-1:0]   vco_freq;
  logic [FB_W-1:0]    feedback_divider;
  logic [RATIO_W-1:0] post_divider;
  logic [CODE_W-1:0]  post_code;
  logic [FB_W-1:0]    divider_word;
  logic               no_fit;

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int          quiet_cycles = 0;

  divider_scoreboard sb = new();

  pll_divider_select uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr           (cfg_wr),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .pixel_clock      (pixel_clock),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .clamped_clock    (clamped_clock),
    .vco_freq         (vco_freq),
    .feedback_divider (feedback_divider),
    .post_divider     (post_divider),
    .post_code        (post_code),
    .divider_word     (divider_word),
    .no_fit           (no_fit)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    divider_pick_t got;
    if (!rst && pop && !empty) begin
      got.clamped_clock    = clamped_clock;
      got.vco_freq         = vco_freq;
      got.feedback_divider = feedback_divider;
      got.post_divider     = post_divider;
      got.post_code        = post_code;
      got.divider_word     = divider_word;
      got.no_fit           = no_fit;
      sb.check_result(got);
    end
  end

  // ends the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("pll_divider_select regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [CLK_W-1:0] pixel);
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel_clock <= pixel;
    do @(posedge clk); while (full);
    sb.note_request(pixel);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // all requests are out, so the limits can change
  task automatic settle();
    push <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_limits(input logic [CLK_W-1:0] max_vco,
                             input logic [CLK_W-1:0] min_vco,
                             input logic [CLK_W-1:0] ref_clk,
                             input logic [RDIV_W-1:0] ref_div);
    cfg_idx_t         regs[4] = '{CFG_MAX_VCO, CFG_MIN_VCO, CFG_REF_CLK, CFG_REF_DIV};
    logic [CLK_W-1:0] vals[4];
    vals = '{max_vco, min_vco, ref_clk, {6'd0, ref_div}};
    for (int i = 0; i < 4; i++) begin
      cfg_wr <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      sb.set_limit(regs[i], vals[i]);
      @(posedge clk);
    end
    cfg_wr <= 1'b0;
  endtask

  task automatic load_random_limits();
    logic [CLK_W-1:0] max_vco;
    logic [CLK_W-1:0] min_vco;
    logic [CLK_W-1:0] ref_clk;
    max_vco = ($urandom_range(9) < 8) ? 16'($urandom_range(4000, 65535))
                                      : 16'($urandom_range(65535));
    if ($urandom_range(9) == 0) begin
      min_vco = 16'($urandom_range(max_vco, 65535));
    end else begin
      min_vco = 16'($urandom_range(0, max_vco));
    end
    case ($urandom_range(19))
      0:       ref_clk = '0;
      1, 2:    ref_clk = 16'($urandom_range(1, 16));
      3, 4, 5: ref_clk = 16'($urandom_range(65535));
      default: ref_clk = 16'($urandom_range(1, 4000));
    endcase
    load_limits(max_vco, min_vco, ref_clk, 10'($urandom_range(2, 1023)));
  endtask

  // half the requests aimed at one post divider window, the rest anywhere or up to the max vco limit
  function automatic logic [CLK_W-1:0] pick_pixel();
    int unsigned ratios[NUM_POST] = '{1, 2, 4, 8, 3, 16, 6, 12};
    int unsigned sel;
    int unsigned target;
    int unsigned dot;
    sel = $urandom_range(9);
    if (sel < 3) return 16'($urandom_range(65535));
    if (sel < 5) return 16'($urandom_range(0, sb.limits.max_vco));
    target = $urandom_range(sb.limits.min_vco, sb.limits.max_vco);
    dot = target / ratios[$urandom_range(NUM_POST - 1)] + $urandom_range(2);
    dot = (dot > 0) ? dot - 1 : 0;
    return (dot > 65535) ? 16'hFFFF : 16'(dot);
  endfunction

  initial begin
    logic [CLK_W-1:0] dflt_pixels[14];
    dflt_pixels = '{
      16'd0, 16'd65535, 16'd35000, 16'd35001, 16'd20000, 16'd12000, 16'd6000,
      16'd3000, 16'd9000, 16'd2000, 16'd4500, 16'd2300, 16'd1666, 16'd1667};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 22;
    recv_gap_pct = 66;

    // reset limits: one request per post divider, clamps and misses
    foreach (dflt_pixels[i]) send_request(dflt_pixels[i]);
    settle();
    // inverted limits
    load_limits(16'd1000, 16'd50000, RST_REF_CLK, RST_REF_DIV);
    send_request(16'd500);
    send_request(16'd60000);
    settle();
    // zero reference clock saturates the feedback divider
    load_limits(16'd35000, 16'd20000, 16'd0, 10'd12);
    send_request(16'd30000);
    send_request(16'd4500);
    settle();
    // wide feedback runs into the code bits
    load_limits(16'd35000, 16'd20000, 16'd1, 10'd1023);
    send_request(16'd12000);
    send_request(16'd2300);
    settle();
    load_limits(16'd65535, 16'd0, 16'd65535, 10'd2);
    send_request(16'd0);
    send_request(16'd65535);
    settle();
    load_limits(16'd0, 16'd0, 16'd1, 10'd1023);
    send_request(16'd12345);
    send_request(16'd1);
    settle();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase / 4)
        0: begin
          send_gap_pct = 22;
          recv_gap_pct = 66;
        end
        1: begin
          send_gap_pct = 66;
          recv_gap_pct = 22;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      load_random_limits();
      for (int n = 0; n < 85; n++) begin
        if (n == 42 && phase % 3 == 1) begin
          push <= 1'b0;
          wait_drained();
        end
        send_request(pick_pixel());
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("pll_divider_select regression: pass");
    end else begin
      $display("pll_divider_select regression: fail");
    end
    $finish;
  end

endmodule
